FILE: hw/rtl/prd_pkg.sv
package prd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PHASE_BITS = 16;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WREG_BITS  = COL_BITS + 1;
  localparam int ROW_BITS   = 16;
  localparam int TOTAL_BITS = 26;

  localparam int IN_DATA_W  = ((PHASE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS = ROW_BITS + COL_BITS + TOTAL_BITS;
  localparam int OUT_DATA_W = ((OUT_FIELDS + 7) / 8) * 8;

  localparam int TURN      = 1 << PHASE_BITS;
  localparam int HALF_TURN = 1 << (PHASE_BITS - 1);

  localparam logic [WREG_BITS-1:0]  WIDTH_RESET  = WREG_BITS'(1024);
  localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = ROW_BITS'(1024);
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX    = {TOTAL_BITS{1'b1}};

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_POSITIVE = 2'd1;
  localparam logic [1:0] KIND_NEGATIVE = 2'd2;
  localparam logic [1:0] KIND_SKIPPED  = 2'd3;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic signed [PHASE_BITS-1:0] phase_t;
  typedef logic signed [PHASE_BITS:0]   diff_t;
  typedef logic signed [PHASE_BITS+2:0] sum_t;
  typedef logic [COL_BITS-1:0]          col_t;

  typedef struct packed {
    phase_t phase;
    logic   free;
  } line_entry_t;

  function automatic diff_t wrap_diff(phase_t a, phase_t b);
    diff_t d;
    d = diff_t'(a) - diff_t'(b);
    if (d <= -diff_t'(HALF_TURN)) begin
      d = d + diff_t'(TURN);
    end else if (d > diff_t'(HALF_TURN)) begin
      d = d - diff_t'(TURN);
    end
    return d;
  endfunction

endpackage

FILE: hw/rtl/prd_line_store.sv
module prd_line_store (
  input  logic                 clk,
  input  logic                 en,
  input  prd_pkg::col_t        addr,
  input  prd_pkg::line_entry_t wr_entry,
  output prd_pkg::line_entry_t rd_entry
);
  import prd_pkg::*;

  line_entry_t mem [MAX_WIDTH];

  // read-first: the pixel above comes out as this row's pixel goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rd_entry  <= mem[addr];
      mem[addr] <= wr_entry;
    end
  end

endmodule

FILE: hw/rtl/phase_residue_detector.sv
// Goldstein residue detector on 2x2 windows of a wrapped phase image.
// Input stream: one pixel per request in raster order, s_tdata holds the
// phase (one turn is 2^16 counts), s_tuser the free flag. Output stream:
// one request per interior window, issued as its bottom-right pixel has
// been taken; m_tdata holds row, column and running residue total,
// m_tuser the class, m_tlast marks the last window of the frame.
// Image width and height are set over the APB port (0x0 and 0x4); any
// write restarts the frame and must only be made while the block is idle.
// Throughput is one pixel per clock unless the output stalls, set by the
// single-port line store, read and written at the same column in the
// cycle a pixel is taken. The compute stage and output register follow.
// A result waits in the output register while m_tready is low; one more
// pixel is held in the compute stage, after which s_tready drops.
// Reset clears the position and residue counters and restores width and
// height to 1024; the line store is not cleared, as each row is written
// before it is read in the same frame.
module phase_residue_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [prd_pkg::IN_DATA_W-1:0]   s_tdata,   // phase_value
  input  logic                            s_tuser,   // pixel_free
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [prd_pkg::OUT_DATA_W-1:0]  m_tdata,   // row_index, column_index, residue_total
  output logic [1:0]                      m_tuser,   // residue_kind
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import prd_pkg::*;

  logic [WREG_BITS-1:0]  image_width;
  logic [ROW_BITS-1:0]   image_height;
  logic [WREG_BITS-1:0]  eff_width;
  logic [ROW_BITS-1:0]   eff_height;
  logic                  cfg_write;

  col_t                  column_count;
  logic [ROW_BITS-1:0]   row_count;
  logic [TOTAL_BITS-1:0] residue_counter;
  phase_t                left_phase;
  phase_t                upper_left_phase;
  logic                  upper_left_free;

  logic                  s1_valid;
  phase_t                s1_phase;
  logic                  s1_emit;
  logic                  s1_last;
  logic [ROW_BITS-1:0]   s1_row;
  col_t                  s1_col;

  logic                  in_take;
  logic                  s1_adv;
  logic                  col_end;
  logic                  row_end;
  line_entry_t           wr_entry;
  line_entry_t           rd_entry;
  sum_t                  edge_sum;
  logic [1:0]            kind;
  logic [TOTAL_BITS-1:0] total_next;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WREG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[ROW_BITS-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width < WREG_BITS'(3)) begin
      eff_width = WREG_BITS'(3);
    end else if (image_width > WREG_BITS'(MAX_WIDTH)) begin
      eff_width = WREG_BITS'(MAX_WIDTH);
    end else begin
      eff_width = image_width;
    end
    if (image_height < ROW_BITS'(3)) begin
      eff_height = ROW_BITS'(3);
    end else begin
      eff_height = image_height;
    end
  end

  // handshake
  assign s1_adv   = s1_valid & (~m_tvalid | m_tready);
  assign s_tready = ~s1_valid | s1_adv;
  assign in_take  = s_tvalid & s_tready;

  // stage 0: position and line store access
  assign col_end  = ({1'b0, column_count} == eff_width - WREG_BITS'(1));
  assign row_end  = (row_count == eff_height - ROW_BITS'(1));
  assign wr_entry = '{phase: phase_t'(s_tdata[PHASE_BITS-1:0]), free: s_tuser};

  prd_line_store u_line_store (
    .clk      (clk),
    .en       (in_take),
    .addr     (column_count),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_write) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_take) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_count + ROW_BITS'(1);
      end else begin
        column_count <= column_count + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_phase <= wr_entry.phase;
      s1_emit  <= (row_count >= ROW_BITS'(2)) & (column_count >= col_t'(2));
      s1_last  <= row_end & col_end;
      s1_row   <= row_count - ROW_BITS'(1);
      s1_col   <= column_count - col_t'(1);
    end
  end

  // stage 1: window sum, residue class and running total
  always_comb begin
    edge_sum = sum_t'(wrap_diff(left_phase, upper_left_phase))
             + sum_t'(wrap_diff(s1_phase, left_phase))
             + sum_t'(wrap_diff(rd_entry.phase, s1_phase))
             + sum_t'(wrap_diff(upper_left_phase, rd_entry.phase));
    if (!upper_left_free) begin
      kind = KIND_SKIPPED;
    end else if (edge_sum == sum_t'(TURN)) begin
      kind = KIND_POSITIVE;
    end else if (edge_sum == -sum_t'(TURN)) begin
      kind = KIND_NEGATIVE;
    end else begin
      kind = KIND_NONE;
    end
    if ((kind == KIND_POSITIVE || kind == KIND_NEGATIVE) && residue_counter != TOTAL_MAX) begin
      total_next = residue_counter + TOTAL_BITS'(1);
    end else begin
      total_next = residue_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_phase       <= '0;
      upper_left_phase <= '0;
      upper_left_free  <= 1'b0;
      residue_counter  <= '0;
    end else if (cfg_write) begin
      residue_counter <= '0;
    end else if (s1_adv) begin
      left_phase       <= s1_phase;
      upper_left_phase <= rd_entry.phase;
      upper_left_free  <= rd_entry.free;
      if (s1_emit) begin
        residue_counter <= s1_last ? '0 : total_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      m_tdata <= OUT_DATA_W'({total_next, s1_col, s1_row});
      m_tuser <= kind;
      m_tlast <= s1_last;
    end
  end

  // checks
  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < eff_width)
    else $error("column count beyond image width");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_tvalid && !m_tready && !in_take |=> s1_valid && $stable(s1_col))
    else $error("compute stage lost while output stalled");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    !cfg_write && !(s1_adv && s1_last) |=>
      residue_counter == $past(residue_counter) ||
      residue_counter == $past(residue_counter) + TOTAL_BITS'(1))
    else $error("residue counter jumped");

  a_result_needs_stage: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |=> !m_tvalid || $past(s1_valid))
    else $error("result issued without a window in flight");

endmodule

FILE: test/phase_residue_detector_tb.sv
`timescale 1ns / 100ps

module phase_residue_detector_tb;
  import prd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PERCENT = 27;
  localparam int THIRD_TURN   = 21845;

  class residue_scoreboard;
    typedef struct {
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      logic [1:0]            kind;
      logic [TOTAL_BITS-1:0] total;
      logic                  last;
    } window_t;

    int unsigned width_reg;
    int unsigned height_reg;
    phase_t      row_above_phase [MAX_WIDTH];
    bit          row_above_free [MAX_WIDTH];
    phase_t      left_ph;
    phase_t      corner_ph;
    bit          corner_free;
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned residue_count;
    window_t     awaited[$];
    int unsigned mismatches;

    function new();
      width_reg   = WIDTH_RESET;
      height_reg  = HEIGHT_RESET;
      left_ph     = '0;
      corner_ph   = '0;
      corner_free = 1'b0;
      mismatches  = 0;
      foreach (row_above_phase[i]) begin
        row_above_phase[i] = '0;
        row_above_free[i]  = 1'b0;
      end
      restart();
    endfunction

    function void restart();
      col_pos       = 0;
      row_pos       = 0;
      residue_count = 0;
    endfunction

    function void write_register(logic idx, logic [31:0] value);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = value[WREG_BITS-1:0];
      end else begin
        height_reg = value[ROW_BITS-1:0];
      end
      restart();
    endfunction

    function int wrapped(int a, int b);
      int d;
      d = a - b;
      if (d <= -HALF_TURN) begin
        d = d + TURN;
      end else if (d > HALF_TURN) begin
        d = d - TURN;
      end
      return d;
    endfunction

    function void note_pixel(phase_t ph, bit fr);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      phase_t      up_ph;
      bit          up_fr;
      int          loop_sum;
      logic [1:0]  kind;
      window_t     win;
      w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h = (height_reg < 3) ? 3 : height_reg;
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      up_ph = row_above_phase[c];
      up_fr = row_above_free[c];
      if (r >= 2 && c >= 2) begin
        if (corner_free) begin
          loop_sum = wrapped(left_ph, corner_ph) + wrapped(ph, left_ph)
                   + wrapped(up_ph, ph) + wrapped(corner_ph, up_ph);
          if (loop_sum == TURN) begin
            kind = KIND_POSITIVE;
          end else if (loop_sum == -TURN) begin
            kind = KIND_NEGATIVE;
          end else begin
            kind = KIND_NONE;
          end
          if (kind != KIND_NONE && residue_count < TOTAL_MAX) begin
            residue_count++;
          end
        end else begin
          kind = KIND_SKIPPED;
        end
        win.row   = ROW_BITS'(r - 1);
        win.col   = COL_BITS'(c - 1);
        win.kind  = kind;
        win.total = TOTAL_BITS'(residue_count);
        win.last  = (r == h - 1) && (c == w - 1);
        awaited = {awaited, win};
      end
      corner_ph          = up_ph;
      corner_free        = up_fr;
      row_above_phase[c] = ph;
      row_above_free[c]  = fr;
      left_ph            = ph;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r = 0;
          residue_count = 0;
        end
      end
      col_pos = c;
      row_pos = r;
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_window(logic [ROW_BITS-1:0] row, logic [COL_BITS-1:0] col,
                      logic [1:0] kind, logic [TOTAL_BITS-1:0] total, logic last);
      window_t want;
      if (awaited.size() == 0) begin
        report("unexpected result row", row, 0);
      end else begin
        want = awaited.pop_front();
        if (row !== want.row) report("row_index", row, want.row);
        if (col !== want.col) report("column_index", col, want.col);
        if (kind !== want.kind) report("residue_kind", kind, want.kind);
        if (total !== want.total) report("residue_total", total, want.total);
        if (last !== want.last) report("frame_last", last, want.last);
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // phase_value
  logic                  s_tuser;   // pixel_free
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // row_index, column_index, residue_total
  logic [1:0]            m_tuser;   // residue_kind
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  residue_scoreboard windows = new();
  int unsigned cycles;
  bit          gaps_on;
  bit          hold_off;

  phase_t demo_phase [24] = '{
    32767, -32768, 0, 0,  0, 0, 0, 0,  0, THIRD_TURN, -THIRD_TURN, 0,
    0, 0, 0, 0,  0, 0, 0, 0,  0, -THIRD_TURN, THIRD_TURN, 0
  };
  bit demo_free [24] = '{
    0, 0, 0, 0,  1, 1, 1, 1,  1, 1, 1, 1,
    1, 1, 1, 1,  1, 1, 0, 1,  1, 1, 1, 1
  };

  phase_residue_detector DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL phase_residue_detector");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        windows.check_window(m_tdata[ROW_BITS-1:0],
                             m_tdata[ROW_BITS +: COL_BITS],
                             m_tuser,
                             m_tdata[ROW_BITS+COL_BITS +: TOTAL_BITS],
                             m_tlast);
      end
      if (s_tvalid && s_tready) begin
        windows.note_pixel(s_tdata[PHASE_BITS-1:0], s_tuser);
      end
    end
  end

  // result side, with a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        repeat (HOLD_CYCLES) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic phase_t random_phase();
    int v;
    case ($urandom_range(3))
      1: begin
        case ($urandom_range(3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      2: v = (int'($urandom_range(2)) - 1) * THIRD_TURN + int'($urandom_range(64)) - 32;
      default: v = int'($urandom);
    endcase
    return phase_t'(v);
  endfunction

  task send_pixel(input phase_t ph, input logic fr);
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'(ph);
    s_tuser  <= fr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task wait_idle();
    s_tvalid <= 1'b0;
    while (windows.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_register(input logic idx, input logic [31:0] value);
    logic [31:0] mask;
    mask    = (idx == REG_IMAGE_WIDTH) ? ((32'd1 << WREG_BITS) - 1) : ((32'd1 << ROW_BITS) - 1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    windows.write_register(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== (value & mask)) windows.report("register readback", prdata, value & mask);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task random_frames(input logic [31:0] w, input logic [31:0] h, input int count,
                     input bit squeeze);
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_IMAGE_HEIGHT, h);
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 4) hold_off = 1'b1;
      if (squeeze && i == count / 2) wait_idle();
      send_pixel(random_phase(), $urandom_range(99) < 85);
    end
    wait_idle();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    gaps_on  = 1'b1;
    hold_off = 1'b0;
    cycles   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset geometry, first row only
    for (int i = 0; i < 40; i++) begin
      send_pixel(random_phase(), $urandom_range(99) < 85);
    end
    wait_idle();

    // two small frames: positive, none, negative, skipped
    write_register(REG_IMAGE_WIDTH, 32'd4);
    write_register(REG_IMAGE_HEIGHT, 32'd0);
    for (int i = 0; i < 24; i++) begin
      send_pixel(demo_phase[i], demo_free[i]);
    end
    wait_idle();

    random_frames(32'd5, 32'd4, 60, 1'b0);
    random_frames(32'd1, 32'd2, 45, 1'b0);
    random_frames(32'd2047, 32'd3, 48, 1'b0);
    random_frames(32'd3, 32'd65535, 90, 1'b0);
    gaps_on = 1'b0;
    random_frames(32'd17, 32'd9, 17 * 9, 1'b0);
    gaps_on = 1'b1;
    random_frames(32'd8, 32'd5, 120, 1'b1);
    random_frames(32'd1024, 32'd1, 40, 1'b0);

    wait_idle();
    repeat (8) @(negedge clk);
    if (windows.mismatches == 0) begin
      $display("PASS phase_residue_detector");
    end else begin
      $display("FAIL phase_residue_detector");
    end
    $finish;
  end

endmodule
